FILE: rtl/length_bcc_frame_checker_assert.svh
// Assertion macros shared by the frame checker RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LENGTH_BCC_FRAME_CHECKER_ASSERT_SVH
`define LENGTH_BCC_FRAME_CHECKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LBFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

FILE: rtl/lbfc_pkg.sv
// Package for the length/BCC frame checker: verdict codes, result word type
// and frame layout constants. No dependencies.
package lbfc_pkg;

    // Width of the byte position counter: header, up to 65535 payload bytes,
    // check byte and end byte all fit.
    localparam int PosW = 17;

    // Positions of the header bytes within a frame.
    localparam logic [PosW-1:0] PosStart = 17'd0;
    localparam logic [PosW-1:0] PosLenHi = 17'd1;
    localparam logic [PosW-1:0] PosLenLo = 17'd2;
    localparam logic [PosW-1:0] HdrLen   = 17'd3;

    // Highest position the counter can reach (the end byte of a full frame).
    localparam logic [PosW-1:0] MaxPos   = 17'd65539;

    // Reset values of the marker registers.
    localparam logic [7:0] StartMarkerRst = 8'h02;
    localparam logic [7:0] EndMarkerRst   = 8'h03;

    // Register indexes of the configuration port.
    localparam logic CfgStartMarker = 1'b0;
    localparam logic CfgEndMarker   = 1'b1;

    // Minimum payload length that holds a full status word.
    localparam logic [15:0] MinLen = 16'd2;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_BAD_START = 3'd1,
        VERDICT_BAD_END  = 3'd2,
        VERDICT_CHECK    = 3'd3,
        VERDICT_STATUS   = 3'd4,
        VERDICT_SHORT    = 3'd5
    } verdict_t;

    // One result word as it sits in the output register.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        verdict_t    verdict;
        logic [15:0] status_word;
    } result_t;

endpackage

FILE: rtl/length_bcc_frame_checker.sv
// Length/BCC frame checker: parses start, length, payload, check and end bytes.
// Depends on lbfc_pkg and length_bcc_frame_checker_assert.svh.
//
// Usage
//   The s_ channel takes one received byte per word: s_tdata[7:0] is the byte
//   and s_tuser high drops any partial frame and takes the byte as a start byte.
//   The m_ channel gives one word for each payload byte (m_tuser[0] high,
//   byte in m_tdata[7:0]) and one word at each end byte (m_tuser[1] high,
//   verdict and captured status word in m_tdata). Header and check bytes give
//   no output word.
//   Throughput is one byte per cycle while s_tready is high; all parsing is
//   one pass of compare and XOR logic from the accepted byte into the frame
//   state and output register. A result is registered as its byte is accepted:
//   in the output register, or in the skid register if the output one is held.
//   When the receiver stalls, a skid register takes one further result while
//   s_tready stays high; s_tready falls only once both registers are full,
//   and rises again in the cycle after the output register is taken.
//   Reset (aresetn low, synchronous) clears the frame state, empties both
//   output registers and sets the markers back to 0x02 and 0x03.
//   The markers are written through cfg_wr_en/cfg_index/cfg_wdata while idle.
module length_bcc_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    // Received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] restart
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [10:8] verdict,
                                   // [26:11] status_word, [31:27] zero
    output logic [1:0]  m_tuser    // [0] payload_valid, [1] frame_done
);
    import lbfc_pkg::*;

    // Configuration and frame state
    logic [7:0]      start_marker_reg;
    logic [7:0]      end_marker_reg;
    logic [PosW-1:0] pos_reg,        pos_next;
    logic [15:0]     len_reg,        len_next;
    logic [7:0]      xor_reg,        xor_next;
    logic            start_bad_reg,  start_bad_next;
    logic [15:0]     status_reg,     status_next;
    logic [7:0]      check_reg,      check_next;

    // Output register and skid register
    logic            out_valid_reg;
    result_t         out_data_reg;
    logic            skid_valid_reg;
    result_t         skid_data_reg;

    logic            s_accept;
    logic            m_pop;
    logic            res_valid;
    result_t         res_data;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = out_valid_reg && m_tready;

    // Per-byte parse: next frame state and the result for this byte
    always_comb begin
        logic [PosW-1:0] pos_eff;
        logic [PosW-1:0] idx;
        logic [7:0]      b;
        pos_eff        = s_tuser ? PosStart : pos_reg;
        idx            = pos_eff - HdrLen;
        b              = s_tdata;
        pos_next       = pos_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        start_bad_next = start_bad_reg;
        status_next    = status_reg;
        check_next     = check_reg;
        res_valid      = 1'b0;
        res_data       = '0;
        case (pos_eff)
            PosStart: begin
                start_bad_next = (b != start_marker_reg);
                len_next       = '0;
                xor_next       = '0;
                status_next    = '0;
                check_next     = '0;
                pos_next       = PosLenHi;
            end
            PosLenHi: begin
                len_next = {b, 8'h00};
                pos_next = PosLenLo;
            end
            PosLenLo: begin
                len_next = {len_reg[15:8], b};
                pos_next = HdrLen;
            end
            default: begin
                if (idx < {1'b0, len_reg}) begin
                    // Payload byte: fold into the check and pass it out
                    xor_next = xor_reg ^ b;
                    if (idx == '0) begin
                        status_next = {b, 8'h00};
                    end else if (idx == PosW'(1)) begin
                        status_next = {status_reg[15:8], b};
                    end
                    pos_next              = pos_eff + PosW'(1);
                    res_valid             = 1'b1;
                    res_data.payload_valid = 1'b1;
                    res_data.payload_byte  = b;
                end else if (idx == {1'b0, len_reg}) begin
                    check_next = b;
                    pos_next   = pos_eff + PosW'(1);
                end else begin
                    // End byte: one verdict, in order of priority
                    res_valid           = 1'b1;
                    res_data.frame_done = 1'b1;
                    res_data.status_word = status_reg;
                    if (start_bad_reg) begin
                        res_data.verdict = VERDICT_BAD_START;
                    end else if (b != end_marker_reg) begin
                        res_data.verdict = VERDICT_BAD_END;
                    end else if (check_reg != xor_reg) begin
                        res_data.verdict = VERDICT_CHECK;
                    end else if (len_reg < MinLen) begin
                        res_data.verdict = VERDICT_SHORT;
                    end else if (status_reg != '0) begin
                        res_data.verdict = VERDICT_STATUS;
                    end else begin
                        res_data.verdict = VERDICT_OK;
                    end
                    pos_next = PosStart;
                end
            end
        endcase
    end

    // Marker registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= StartMarkerRst;
            end_marker_reg   <= EndMarkerRst;
        end else if (cfg_wr_en) begin
            if (cfg_index == CfgStartMarker) begin
                start_marker_reg <= cfg_wdata;
            end
            if (cfg_index == CfgEndMarker) begin
                end_marker_reg <= cfg_wdata;
            end
        end
    end

    // Frame state, updated on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            len_reg       <= '0;
            xor_reg       <= '0;
            start_bad_reg <= 1'b0;
            status_reg    <= '0;
            check_reg     <= '0;
        end else if (s_accept) begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            xor_reg       <= xor_next;
            start_bad_reg <= start_bad_next;
            status_reg    <= status_next;
            check_reg     <= check_next;
        end
    end

    // Output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept && res_valid) begin
            if (!out_valid_reg || m_pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (s_accept && res_valid) begin
            if (!out_valid_reg || m_pop) begin
                out_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg.status_word, out_data_reg.verdict,
                       out_data_reg.payload_byte};
    assign m_tuser  = {out_data_reg.frame_done, out_data_reg.payload_valid};

`include "length_bcc_frame_checker_assert.svh"

    // The skid register only fills behind a full output register.
    `LBFC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // Every output word is either a payload byte or a frame verdict.
    `LBFC_ASSERT_SAME(a_one_kind, out_valid_reg,
        out_data_reg.payload_valid != out_data_reg.frame_done)
    // The position never runs past the end byte of a full-length frame.
    `LBFC_ASSERT_SAME(a_pos_bound, 1'b1, pos_reg <= MaxPos)
    // A verdict word returns the parser to the start of a frame.
    `LBFC_ASSERT_NEXT(a_done_rewinds, s_accept && res_valid && res_data.frame_done,
        pos_reg == PosStart)

endmodule

FILE: test/tb_length_bcc_frame_checker.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_bcc_frame_checker: random and hand-built reply frames.
// A built-in frame parser predicts every result word. Needs lbfc_pkg and the checker RTL.
module tb_length_bcc_frame_checker;
    import lbfc_pkg::*;

    localparam int CycleLimit    = 300000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 4;
    localparam int PhaseBytes    = 250;
    localparam int NumPhases     = 6;

    // One received byte as the sender offers it.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } rx_item_t;

    // One predicted result word.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        verdict_t    verdict;
        logic [15:0] status_word;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CfgStartMarker;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;    // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] payload_byte, [10:8] verdict,
                                    // [26:11] status_word, [31:27] zero
    logic [1:0]  m_tuser;           // [0] payload_valid, [1] frame_done

    length_bcc_frame_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Bytes waiting to be offered and result words still to arrive.
    rx_item_t      pending_bytes[$];
    frame_result_t expected_words[$];

    // Frame parser state and its copy of the marker registers.
    logic [7:0]  mk_start = StartMarkerRst;
    logic [7:0]  mk_end = EndMarkerRst;
    logic [16:0] frame_pos = PosStart;
    logic [15:0] frame_len = 16'h0000;
    logic [7:0]  xor_sum = 8'h00;
    logic        start_bad = 1'b0;
    logic [15:0] status_cap = 16'h0000;
    logic [7:0]  check_rx = 8'h00;

    // Idling, hold-off control and run statistics.
    int sender_idle_pct = 6;
    int receiver_idle_pct = 53;
    int holdoffs_asked = 0;
    int holdoffs_started = 0;
    int stall_left = 0;
    logic ready_next;
    int cycle_count = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int payload_words = 0;
    int frame_verdicts = 0;
    int settings_used = 1;
    int mismatch_count = 0;
    int verdict_tally[6];
    bit need_restart = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Advance the frame parser by one accepted byte and record any result word.
    task automatic parse_frame_byte(input rx_item_t item);
        frame_result_t res;
        logic [16:0]   idx;
        logic          emit;
        res = '0;
        emit = 1'b0;
        if (item.restart) frame_pos = PosStart;
        if (frame_pos == PosStart) begin
            start_bad = (item.rx_byte != mk_start);
            frame_len = 16'h0000;
            xor_sum = 8'h00;
            status_cap = 16'h0000;
            check_rx = 8'h00;
            frame_pos = PosLenHi;
        end else if (frame_pos == PosLenHi) begin
            frame_len = {item.rx_byte, 8'h00};
            frame_pos = PosLenLo;
        end else if (frame_pos == PosLenLo) begin
            frame_len[7:0] = item.rx_byte;
            frame_pos = HdrLen;
        end else begin
            idx = frame_pos - HdrLen;
            if (idx < {1'b0, frame_len}) begin
                xor_sum ^= item.rx_byte;
                if (idx == 17'd0) status_cap = {item.rx_byte, 8'h00};
                else if (idx == 17'd1) status_cap[7:0] = item.rx_byte;
                frame_pos = frame_pos + 17'd1;
                emit = 1'b1;
                res.payload_valid = 1'b1;
                res.payload_byte = item.rx_byte;
            end else if (idx == {1'b0, frame_len}) begin
                check_rx = item.rx_byte;
                frame_pos = frame_pos + 17'd1;
            end else begin
                // End byte: the first failing check decides the verdict.
                if (start_bad) res.verdict = VERDICT_BAD_START;
                else if (item.rx_byte != mk_end) res.verdict = VERDICT_BAD_END;
                else if (check_rx != xor_sum) res.verdict = VERDICT_CHECK;
                else if (frame_len < MinLen) res.verdict = VERDICT_SHORT;
                else if (status_cap != 16'h0000) res.verdict = VERDICT_STATUS;
                else res.verdict = VERDICT_OK;
                res.frame_done = 1'b1;
                res.status_word = status_cap;
                frame_pos = PosStart;
                emit = 1'b1;
            end
        end
        if (emit) expected_words.push_back(res);
    endtask

    // Driver: keeps a word on offer until it is taken, idling at random in between.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_frame_byte(pending_bytes.pop_front());
                bytes_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_bytes.size() != 0
                        && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_bytes[0].rx_byte;
                    s_tuser <= pending_bytes[0].restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Compare one taken result word with the oldest prediction.
    task automatic check_result_word();
        frame_result_t exp_word;
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected: tdata %0h tuser %0h",
                   m_tdata, m_tuser);
            mismatch_count++;
        end else begin
            exp_word = expected_words.pop_front();
            compare_field("payload_valid", 16'(exp_word.payload_valid), 16'(m_tuser[0]));
            compare_field("payload_byte", 16'(exp_word.payload_byte), 16'(m_tdata[7:0]));
            compare_field("frame_done", 16'(exp_word.frame_done), 16'(m_tuser[1]));
            compare_field("verdict", 16'(exp_word.verdict), 16'(m_tdata[10:8]));
            compare_field("status_word", exp_word.status_word, m_tdata[26:11]);
            compare_field("tdata padding", 16'h0000, 16'(m_tdata[31:27]));
            if (exp_word.frame_done) begin
                frame_verdicts++;
                verdict_tally[exp_word.verdict]++;
            end else begin
                payload_words++;
            end
        end
    endtask

    // Monitor: checks taken words and drives tready, with long hold-offs on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result_word();
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (holdoffs_started != holdoffs_asked) begin
                holdoffs_started++;
                stall_left = HoldOffCycles - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = ($urandom_range(0, 99) >= receiver_idle_pct);
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic r);
        pending_bytes.push_back('{rx_byte: b, restart: r});
        bytes_queued++;
    endtask

    // Build one frame with occasional faults and queue its first keep bytes.
    task automatic queue_frame(input int len, input bit restart_first, input int keep);
        logic [7:0] frame_bytes[$];
        logic [7:0] b;
        logic [7:0] sum;
        bit         zero_status;
        int         i;
        sum = 8'h00;
        zero_status = ($urandom_range(0, 99) < 55);
        b = mk_start;
        if ($urandom_range(0, 9) == 0) begin
            while (b == mk_start) b = 8'($urandom_range(0, 255));
        end
        frame_bytes.push_back(b);
        frame_bytes.push_back(8'(len >> 8));
        frame_bytes.push_back(8'(len));
        for (i = 0; i < len; i++) begin
            b = (zero_status && i < 2) ? 8'h00 : 8'($urandom_range(0, 255));
            sum ^= b;
            frame_bytes.push_back(b);
        end
        if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        b = mk_end;
        if ($urandom_range(0, 9) == 0) begin
            while (b == mk_end) b = 8'($urandom_range(0, 255));
        end
        frame_bytes.push_back(b);
        for (i = 0; i < keep && i < frame_bytes.size(); i++)
            queue_byte(frame_bytes[i], restart_first && i == 0);
    endtask

    // Wait until every byte is taken and every result has arrived, then let
    // the pipeline settle.
    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Write the start marker and then the end marker; only called while idle.
    task automatic set_markers(input logic [7:0] start_val, input logic [7:0] end_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CfgStartMarker;
        cfg_wdata <= start_val;
        @(posedge aclk);
        cfg_index <= CfgEndMarker;
        cfg_wdata <= end_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mk_start = start_val;
        mk_end = end_val;
        settings_used++;
    endtask

    // Stimulus sequence.
    initial begin
        int phase;
        int phase_base;
        int roll;
        int len;
        int n;
        bit paused;
        logic [7:0] mk_a;
        foreach (verdict_tally[k]) verdict_tally[k] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Hand-built frames under the reset markers.
        // Good frame, two zero status bytes.
        queue_byte(8'h02, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h02, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h03, 1'b0);
        // One payload byte of all ones: too short, status in the high half.
        queue_byte(8'h02, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h03, 1'b0);
        // Wrong start byte, taken with restart, empty payload.
        queue_byte(8'h00, 1'b1); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'h03, 1'b0);
        // Partial frame with a huge length, dropped by the restart that follows.
        queue_byte(8'h02, 1'b0); queue_byte(8'hFF, 1'b0);
        // Wrong end byte.
        queue_byte(8'h02, 1'b1); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0);

        for (phase = 0; phase < NumPhases; phase++) begin
            wait_for_drain();
            sender_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 53 : 0;
            receiver_idle_pct = (phase < 2) ? 53 : (phase < 4) ? 6 : 0;
            case (phase)
                1: set_markers(8'h00, 8'hFF);
                2: set_markers(8'hFF, 8'h00);
                3: set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                4: begin
                    mk_a = 8'($urandom_range(0, 255));
                    set_markers(mk_a, mk_a);
                end
                5: set_markers(StartMarkerRst, EndMarkerRst);
                default: ;
            endcase
            @(negedge aclk);
            phase_base = bytes_queued;
            paused = 1'b0;

            // Long frame against a stalled receiver fills the block up.
            if (phase == 1 || phase == 4) begin
                holdoffs_asked++;
                queue_frame(260, 1'b1, 265);
                need_restart = 1'b0;
            end
            // Runaway length field, cut short by a later restart.
            if (phase == 2) begin
                queue_byte(mk_start, 1'b1);
                queue_byte(8'hFF, 1'b0);
                queue_byte(8'hFF, 1'b0);
                for (n = 0; n < 20; n++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
                need_restart = 1'b1;
            end

            while (bytes_queued - phase_base < PhaseBytes) begin
                // Sender stops mid-phase until all outstanding results are in.
                if (phase == 3 && !paused && bytes_queued - phase_base > PhaseBytes / 2) begin
                    paused = 1'b1;
                    wait_for_drain();
                    @(negedge aclk);
                end
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                      : $urandom_range(9, 40);
                    queue_frame(len, need_restart || ($urandom_range(0, 4) == 0), len + 5);
                    need_restart = 1'b0;
                end else if (roll < 86) begin
                    len = $urandom_range(0, 12);
                    queue_frame(len, need_restart, $urandom_range(1, len + 4));
                    need_restart = 1'b1;
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) queue_byte(8'($urandom_range(0, 255)),
                                          ($urandom_range(0, 3) == 0));
                    need_restart = 1'b1;
                end
            end
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d bytes under %0d marker settings: %0d payload words, %0d verdicts",
                 bytes_accepted, settings_used, payload_words, frame_verdicts);
        $display("Verdicts: ok %0d, bad start %0d, bad end %0d, check %0d, status %0d, short %0d",
                 verdict_tally[VERDICT_OK], verdict_tally[VERDICT_BAD_START],
                 verdict_tally[VERDICT_BAD_END], verdict_tally[VERDICT_CHECK],
                 verdict_tally[VERDICT_STATUS], verdict_tally[VERDICT_SHORT]);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
